/* rtl/core/pch_pkg.sv */
`default_nettype none

package pch_pkg;

  localparam int CHANNELS = 3;
  localparam int CHAN_W = 2;
  localparam int SAMPLE_W = 8;
  localparam int CFG_W = 5;
  localparam int COUNT_W = 11;
  localparam int BIN_OUT_W = 4;
  localparam int RECIP_W = 13;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W = SAMPLE_W + RECIP_W;
  localparam int IN_TDATA_W = CHANNELS * SAMPLE_W;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W = OUT_TDATA_W - CHAN_W - BIN_OUT_W - COUNT_W;

  localparam int DEF_MAX_BINS = 16;
  localparam int DEF_MAX_PATCH_PIXELS = 1024;
  localparam logic [CFG_W-1:0] RESET_BINS = 5'd16;
  localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(CHANNELS - 1);

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } drain_state_t;

  typedef struct packed {
    logic load;
    logic update;
    logic clear;
  } lane_ctrl_t;

  typedef struct packed {
    logic busy;
    logic clear;
  } drain_stat_t;

  // Bins in use after clamping to the range one to max_n.
  function automatic logic [CFG_W-1:0] active_bins(input logic [CFG_W-1:0] value,
                                                   input logic [CFG_W-1:0] max_n);
    logic [CFG_W-1:0] n;
    n = value;
    if (n == '0) begin
      n = CFG_W'(1);
    end
    if (n > max_n) begin
      n = max_n;
    end
    return n;
  endfunction

  // Rounded-up reciprocal 2^16 / (255 / n). The product with an 8-bit sample,
  // shifted down by sixteen, gives the exact quotient by the bin width.
  function automatic logic [RECIP_W-1:0] recip_of(input logic [CFG_W-1:0] n);
    logic [RECIP_W-1:0] r;
    unique case (n)
      5'd1:    r = 13'd258;
      5'd2:    r = 13'd517;
      5'd3:    r = 13'd772;
      5'd4:    r = 13'd1041;
      5'd5:    r = 13'd1286;
      5'd6:    r = 13'd1561;
      5'd7:    r = 13'd1821;
      5'd8:    r = 13'd2115;
      5'd9:    r = 13'd2341;
      5'd10:   r = 13'd2622;
      5'd11:   r = 13'd2850;
      5'd12:   r = 13'd3121;
      5'd13:   r = 13'd3450;
      5'd14:   r = 13'd3641;
      5'd15:   r = 13'd3856;
      5'd16:   r = 13'd4370;
      5'd17:   r = 13'd4370;
      5'd18:   r = 13'd4682;
      5'd19:   r = 13'd5042;
      5'd20:   r = 13'd5462;
      5'd21:   r = 13'd5462;
      default: r = 13'd258;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/pch_lane.sv */
`default_nettype none

module pch_lane import pch_pkg::*; #(
  parameter int MAX_BINS = DEF_MAX_BINS,
  parameter int MAX_PATCH_PIXELS = DEF_MAX_PATCH_PIXELS,
  localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire lane_ctrl_t           ctrl,
  input  wire logic [SAMPLE_W-1:0]  sample,
  input  wire logic [RECIP_W-1:0]   recip,
  input  wire logic [CFG_W-1:0]     nlast,
  input  wire logic [BIN_W-1:0]     rd_bin,
  output logic      [COUNT_W-1:0]   rd_count
);

  localparam int ALL_ONES = (1 << COUNT_W) - 1;
  localparam logic [COUNT_W-1:0] COUNT_CAP =
    COUNT_W'((MAX_PATCH_PIXELS < ALL_ONES) ? MAX_PATCH_PIXELS : ALL_ONES);

  logic [PROD_W-1:0]  prod;
  logic [CFG_W-1:0]   quot;
  logic [CFG_W-1:0]   bin;
  logic [COUNT_W-1:0] counts [MAX_BINS];

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      prod <= PROD_W'(sample) * PROD_W'(recip);
    end
  end

  always_comb begin
    quot = prod[PROD_W-1:RECIP_SHIFT];
    bin = (quot > nlast) ? nlast : quot;
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      for (int j = 0; j < MAX_BINS; j++) begin
        counts[j] <= '0;
      end
    end else if (ctrl.update) begin
      for (int j = 0; j < MAX_BINS; j++) begin
        if (bin == CFG_W'(j) && counts[j] < COUNT_CAP) begin
          counts[j] <= counts[j] + 1'b1;
        end
      end
    end
  end

  assign rd_count = counts[rd_bin];

endmodule

`default_nettype wire

/* rtl/core/pch_merge.sv */
`default_nettype none

module pch_merge import pch_pkg::*; #(
  parameter int MAX_BINS = DEF_MAX_BINS,
  localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [CFG_W-1:0]       nlast,
  input  wire logic [COUNT_W-1:0]     rd_count [CHANNELS],
  output logic      [BIN_W-1:0]       rd_bin,
  output drain_stat_t                 stat,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // Fields from bit 0: channel_index, bin_index, bin_count, zero fill.
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                        m_axis_tlast
);

  drain_state_t state, state_next;
  logic [CHAN_W-1:0]          rd_chan;
  logic                       load;
  logic                       final_bin;
  logic [BIN_W+BIN_OUT_W-1:0] bin_ext;
  logic [CHAN_W-1:0]          out_chan;
  logic [BIN_OUT_W-1:0]       out_bin;
  logic [COUNT_W-1:0]         out_count;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (load && final_bin) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    stat.busy = (state == ST_DRAIN);
    load = stat.busy && (!m_axis_tvalid || m_axis_tready);
    final_bin = (rd_chan == LAST_CHAN) && (CFG_W'(rd_bin) == nlast);
    stat.clear = load && final_bin;
    bin_ext = {{BIN_OUT_W{1'b0}}, rd_bin};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rd_chan <= '0;
      rd_bin <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        m_axis_tvalid <= 1'b1;
        if (CFG_W'(rd_bin) == nlast) begin
          rd_bin <= '0;
          rd_chan <= final_bin ? '0 : rd_chan + 1'b1;
        end else begin
          rd_bin <= rd_bin + 1'b1;
        end
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_chan <= rd_chan;
      out_bin <= bin_ext[BIN_OUT_W-1:0];
      out_count <= rd_count[rd_chan];
      m_axis_tlast <= final_bin;
    end
  end

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_count, out_bin, out_chan};

endmodule

`default_nettype wire

/* rtl/core/patch_color_histogram_core.sv */
// Per-channel colour histogram of an image patch.
// The slave stream takes one pixel per transaction: three 8-bit channel
// samples in s_axis_tdata and s_axis_tlast on the patch's final pixel.
// Each channel has its own lane that bins its sample by the configured
// bin width and counts hits with saturation; pixels are taken one per cycle
// outside a drain. From the cycle after the final pixel the block takes no
// pixels until its drain ends and drains the 3 * bins counts on the master
// stream, channel 0 first, bins in ascending order, with m_axis_tlast on
// the very last count. The final pixel's flags are registered in p_valid
// and p_last, which start the drain state, and each count is registered
// for output; one count leaves per cycle while the receiver is ready; a
// stall holds the current count and the drain resumes when m_axis_tready
// returns. After the last count is loaded the counters are cleared and
// pixels of the next patch are taken again. cfg_we with cfg_wdata sets the
// bins in use and is only to be written while the block is idle. Reset
// sets sixteen bins, clears all counters and empties the output register.
`default_nettype none

module patch_color_histogram_core import pch_pkg::*; #(
  parameter int MAX_BINS = DEF_MAX_BINS,
  parameter int MAX_PATCH_PIXELS = DEF_MAX_PATCH_PIXELS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_W-1:0]       cfg_wdata,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // Fields from bit 0: chan0_value, chan1_value, chan2_value.
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic                   s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // Fields from bit 0: channel_index, bin_index, bin_count, zero fill.
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                        m_axis_tlast
);

  localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam logic [CFG_W-1:0] MAX_N = CFG_W'(MAX_BINS);

  logic [RECIP_W-1:0] recip;
  logic [CFG_W-1:0]   nlast;
  logic [CFG_W-1:0]   n_wr;
  logic               p_valid;
  logic               p_last;
  logic               accept;
  lane_ctrl_t         lane_ctrl;
  drain_stat_t        stat;
  logic [BIN_W-1:0]   rd_bin;
  logic [COUNT_W-1:0] rd_count [CHANNELS];

  assign n_wr = active_bins(cfg_wdata, MAX_N);

  always_ff @(posedge clk) begin
    if (rst) begin
      recip <= recip_of(active_bins(RESET_BINS, MAX_N));
      nlast <= active_bins(RESET_BINS, MAX_N) - 1'b1;
    end else if (cfg_we) begin
      recip <= recip_of(n_wr);
      nlast <= n_wr - 1'b1;
    end
  end

  assign s_axis_tready = !(p_valid && p_last) && !stat.busy;
  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      p_last <= 1'b0;
    end else begin
      p_valid <= accept;
      p_last <= accept && s_axis_tlast;
    end
  end

  always_comb begin
    lane_ctrl.load = accept;
    lane_ctrl.update = p_valid;
    lane_ctrl.clear = stat.clear;
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    pch_lane #(
      .MAX_BINS(MAX_BINS),
      .MAX_PATCH_PIXELS(MAX_PATCH_PIXELS)
    ) u_lane (
      .clk(clk),
      .rst(rst),
      .ctrl(lane_ctrl),
      .sample(s_axis_tdata[c*SAMPLE_W +: SAMPLE_W]),
      .recip(recip),
      .nlast(nlast),
      .rd_bin(rd_bin),
      .rd_count(rd_count[c])
    );
  end

  pch_merge #(
    .MAX_BINS(MAX_BINS)
  ) u_merge (
    .clk(clk),
    .rst(rst),
    .start(p_valid && p_last),
    .nlast(nlast),
    .rd_count(rd_count),
    .rd_bin(rd_bin),
    .stat(stat),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

endmodule

`default_nettype wire
